FILE: rtl/core/msdf_pkg.sv
// Shared types and constants of the multichannel sample demultiplexer.
package msdf_pkg;

    // Ring organization.
    localparam int CHANNELS   = 8;
    localparam int RING_DEPTH = 1024;
    localparam int CH_W       = $clog2(CHANNELS);
    localparam int PTR_W      = $clog2(RING_DEPTH);
    localparam int ADDR_W     = CH_W + PTR_W;
    localparam int MEM_DEPTH  = CHANNELS * RING_DEPTH;

    // Field widths.
    localparam int SAMPLE_W = 12;
    localparam int VALUE_W  = 13;
    localparam int POPCH_W  = 3;
    localparam int COUNT_W  = 4;
    localparam int THR_W    = 10;
    localparam int CMP_W    = (PTR_W > THR_W) ? PTR_W : THR_W;
    localparam int CFG_W    = 10;
    localparam int CFG_IDX_W = 2;

    // Offset removed from a popped sample.
    localparam logic [VALUE_W-1:0] SAMPLE_OFFSET = VALUE_W'(2047);

    // Item kinds.
    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLING_ENABLE = 2'd2;

    // Configuration register values.
    typedef struct packed {
        logic [COUNT_W-1:0] channel_count;
        logic [THR_W-1:0]   block_threshold;
        logic               sampling_enable;
    } cfg_t;

    // Request to the sample memory.
    typedef struct packed {
        logic                wr_en;
        logic                rd_en;
        logic [ADDR_W-1:0]   addr;
        logic [SAMPLE_W-1:0] wdata;
    } mem_req_t;

    // Outcome of one item as decided by the ring control.
    typedef struct packed {
        logic block_ready;
        logic dropped;
        logic pop_hit;
    } step_res_t;

endpackage

FILE: rtl/core/multichannel_sample_demux_fifo_core.sv
// Top level of the multichannel sample demultiplexer with per-channel rings.
//
// Input items arrive on the s_ stream. A push (s_tuser[0] = 0) carries one
// 12-bit ADC sample that goes to the next channel ring in round-robin order;
// s_tuser[1] marks the first sample of a packet and restarts that order.
// A pop (s_tuser[0] = 1) takes the oldest sample of the ring named in
// s_tdata and returns it minus 2047.
// Every item yields exactly one result transfer on the m_ stream.
// A push, an ignored push or an empty pop gives its result in the cycle
// after its transfer, and a new item can be taken every cycle.
// A pop that finds data gives its result after a pass through the registered
// read of the sample memory and then the output register; no new item is
// taken while such a pop is in flight.
// The output register decouples the sides: an item is taken while a result
// waits, as long as that result is taken in the same cycle. While the
// receiver stalls, the result holds and no new item is taken.
// Reset empties all rings and sets the registers to their defaults; the sample memory
// itself needs no clearing pass. Configuration writes go through cfg_we, cfg_index and
// cfg_data; the user makes them while the block is idle, which the block does not enforce.
module multichannel_sample_demux_fifo_core (
    input  logic                              clk,
    input  logic                              rst_n,
    // Input stream.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [15:0]                       s_tdata,  // sample[11:0], channel[14:12], zero
    input  logic [1:0]                        s_tuser,  // action[0], first_in_packet[1]
    // Result stream.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [15:0]                       m_tdata,  // block_ready[0], sample_dropped[1],
                                                        // read_value[14:2], read_valid[15]
    // Configuration writes.
    input  logic                              cfg_we,
    input  logic [msdf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [msdf_pkg::CFG_W-1:0]        cfg_data
);

    msdf_pkg::cfg_t      cfg_reg;
    msdf_pkg::mem_req_t  mem_req;
    msdf_pkg::step_res_t res;
    logic [msdf_pkg::SAMPLE_W-1:0] rdata;

    logic step;
    logic busy_reg;
    logic pend_ready_reg;
    logic out_valid_reg;
    logic out_ready_reg;
    logic out_dropped_reg;
    logic [msdf_pkg::VALUE_W-1:0] out_value_reg;
    logic out_rvalid_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.channel_count   <= msdf_pkg::COUNT_W'(1);
            cfg_reg.block_threshold <= msdf_pkg::THR_W'(1023);
            cfg_reg.sampling_enable <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                msdf_pkg::CFG_CHANNEL_COUNT:
                    cfg_reg.channel_count <= cfg_data[msdf_pkg::COUNT_W-1:0];
                msdf_pkg::CFG_BLOCK_THRESHOLD:
                    cfg_reg.block_threshold <= cfg_data[msdf_pkg::THR_W-1:0];
                msdf_pkg::CFG_SAMPLING_ENABLE:
                    cfg_reg.sampling_enable <= cfg_data[0];
                default:
                    ;
            endcase
        end
    end

    // Take an item when no pop is in flight and the output slot frees up.
    assign s_tready = !busy_reg && (!out_valid_reg || m_tready);
    assign step     = s_tvalid && s_tready;

    msdf_ring_ctrl u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (step),
        .action          (s_tuser[0]),
        .sample          (s_tdata[11:0]),
        .first_in_packet (s_tuser[1]),
        .channel         (s_tdata[14:12]),
        .cfg             (cfg_reg),
        .mem_req         (mem_req),
        .res             (res)
    );

    msdf_sample_ram u_ram (
        .clk   (clk),
        .req   (mem_req),
        .rdata (rdata)
    );

    // Pop in flight: waits for the registered memory read.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= step && res.pop_hit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            pend_ready_reg <= res.block_ready;
        end
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (busy_reg || (step && !res.pop_hit))
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload: loaded directly or from the memory read.
    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            out_ready_reg   <= pend_ready_reg;
            out_dropped_reg <= 1'b0;
            out_value_reg   <= {1'b0, rdata} - msdf_pkg::SAMPLE_OFFSET;
            out_rvalid_reg  <= 1'b1;
        end
        else if (step && !res.pop_hit)
        begin
            out_ready_reg   <= res.block_ready;
            out_dropped_reg <= res.dropped;
            out_value_reg   <= '0;
            out_rvalid_reg  <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_rvalid_reg, out_value_reg, out_dropped_reg, out_ready_reg};

    // No item is taken while a pop waits on the memory.
    a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !s_tready)
        else $error("input taken while a pop read is in flight");

    // Once a pop that hits data has waited on the memory read, its result is valid on the next cycle.
    a_pop_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |=> (m_tvalid && m_tdata[15]))
        else $error("pop result missing after memory read");

    // A result never flags both a drop and a read.
    a_drop_excludes_read: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[1] && m_tdata[15]))
        else $error("result flags both a drop and a read");

    // Memory is never written and read in the same cycle.
    a_single_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_req.wr_en && mem_req.rd_en))
        else $error("sample memory written and read together");

endmodule

FILE: rtl/core/msdf_sample_ram.sv
// Sample memory: one port, synchronous write, registered read.
module msdf_sample_ram (
    input  logic                           clk,
    input  msdf_pkg::mem_req_t             req,
    output logic [msdf_pkg::SAMPLE_W-1:0]  rdata
);

    logic [msdf_pkg::SAMPLE_W-1:0] mem [msdf_pkg::MEM_DEPTH];

    // One access per cycle, write or read, kept by the requester.
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.rd_en)
        begin
            rdata <= mem[req.addr];
        end
    end

endmodule

FILE: rtl/core/msdf_ring_ctrl.sv
// Ring pointers, round-robin channel counter and drop tracking.
module msdf_ring_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           step,
    input  logic                           action,
    input  logic [msdf_pkg::SAMPLE_W-1:0]  sample,
    input  logic                           first_in_packet,
    input  logic [msdf_pkg::POPCH_W-1:0]   channel,
    input  msdf_pkg::cfg_t                 cfg,
    output msdf_pkg::mem_req_t             mem_req,
    output msdf_pkg::step_res_t            res
);

    logic [msdf_pkg::PTR_W-1:0] tail_reg [msdf_pkg::CHANNELS];
    logic [msdf_pkg::PTR_W-1:0] head_reg [msdf_pkg::CHANNELS];
    logic [msdf_pkg::PTR_W-1:0] tail_next [msdf_pkg::CHANNELS];
    logic [msdf_pkg::PTR_W-1:0] head_next [msdf_pkg::CHANNELS];
    logic [msdf_pkg::CH_W-1:0]  next_ch_reg;
    logic [msdf_pkg::CH_W-1:0]  next_ch_next;
    logic                       dropping_reg;
    logic                       dropping_next;

    logic [msdf_pkg::COUNT_W-1:0] active_n;
    logic [msdf_pkg::CH_W-1:0]    start_ch;
    logic                         start_drop;
    logic [msdf_pkg::CH_W-1:0]    push_ch;
    logic [msdf_pkg::COUNT_W-1:0] push_ch_inc;
    logic [msdf_pkg::PTR_W-1:0]   tail_inc;
    logic [msdf_pkg::CH_W-1:0]    pop_ch;
    logic                         pop_nonempty;
    logic [msdf_pkg::PTR_W-1:0]   occ0;

    // Clamp the channel count to the rings that exist.
    always_comb
    begin
        if (cfg.channel_count == '0)
        begin
            active_n = msdf_pkg::COUNT_W'(1);
        end
        else if (cfg.channel_count > msdf_pkg::COUNT_W'(msdf_pkg::CHANNELS))
        begin
            active_n = msdf_pkg::COUNT_W'(msdf_pkg::CHANNELS);
        end
        else
        begin
            active_n = cfg.channel_count;
        end
    end

    // A packet start on a sampled push restarts the counter and ends any dropping.
    assign start_ch   = first_in_packet ? '0 : next_ch_reg;
    assign start_drop = first_in_packet ? 1'b0 : dropping_reg;
    assign push_ch    = (msdf_pkg::COUNT_W'(start_ch) >= active_n) ? '0 : start_ch;
    assign push_ch_inc = msdf_pkg::COUNT_W'(push_ch) + msdf_pkg::COUNT_W'(1);
    assign tail_inc   = tail_reg[push_ch] + msdf_pkg::PTR_W'(1);

    assign pop_ch       = msdf_pkg::CH_W'(channel);
    assign pop_nonempty = (head_reg[pop_ch] != tail_reg[pop_ch]);

    // Next state of pointers and packet tracking for the item in hand.
    always_comb
    begin
        for (int i = 0; i < msdf_pkg::CHANNELS; i++)
        begin
            tail_next[i] = tail_reg[i];
            head_next[i] = head_reg[i];
        end
        next_ch_next  = next_ch_reg;
        dropping_next = dropping_reg;
        mem_req       = '0;
        mem_req.wdata = sample;
        res           = '0;

        if (step)
        begin
            if (action == msdf_pkg::ACT_PUSH)
            begin
                if (cfg.sampling_enable)
                begin
                    next_ch_next  = start_ch;
                    dropping_next = start_drop;
                    if (start_drop)
                    begin
                        res.dropped = 1'b1;
                    end
                    else if (tail_inc == head_reg[push_ch])
                    begin
                        dropping_next = 1'b1;
                        res.dropped   = 1'b1;
                    end
                    else
                    begin
                        mem_req.wr_en     = 1'b1;
                        mem_req.addr      = {push_ch, tail_reg[push_ch]};
                        tail_next[push_ch] = tail_inc;
                        next_ch_next = (push_ch_inc >= active_n) ? '0
                                       : msdf_pkg::CH_W'(push_ch_inc);
                    end
                end
            end
            else if (pop_nonempty)
            begin
                mem_req.rd_en     = 1'b1;
                mem_req.addr      = {pop_ch, head_reg[pop_ch]};
                head_next[pop_ch] = head_reg[pop_ch] + msdf_pkg::PTR_W'(1);
                res.pop_hit       = 1'b1;
            end
        end

        // Channel 0 fill level after this item.
        occ0 = tail_next[0] - head_next[0];
        res.block_ready = (msdf_pkg::CMP_W'(occ0) > msdf_pkg::CMP_W'(cfg.block_threshold));
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < msdf_pkg::CHANNELS; i++)
            begin
                tail_reg[i] <= '0;
                head_reg[i] <= '0;
            end
            next_ch_reg  <= '0;
            dropping_reg <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < msdf_pkg::CHANNELS; i++)
            begin
                tail_reg[i] <= tail_next[i];
                head_reg[i] <= head_next[i];
            end
            next_ch_reg  <= next_ch_next;
            dropping_reg <= dropping_next;
        end
    end

endmodule

FILE: bench/msdf_checker.sv
// Scoreboard for the sample demultiplexer: predicts every result and compares it with the DUT.
module demux_ring_checker
    import msdf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [15:0]          s_tdata,   // sample[11:0], channel[14:12], zero
    input  logic [1:0]           s_tuser,   // action[0], first_in_packet[1]
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [15:0]          m_tdata,   // block_ready[0], sample_dropped[1],
                                            // read_value[14:2], read_valid[15]
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output int                   mismatch_count,
    output int                   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_MAX = 10;

    typedef struct {
        logic                      block_ready;
        logic                      dropped;
        logic signed [VALUE_W-1:0] read_value;
        logic                      read_valid;
    } demux_result_t;

    // Mirror of the rings, the round-robin position and the registers.
    logic [SAMPLE_W-1:0] ring_mem [CHANNELS][RING_DEPTH];
    logic [PTR_W-1:0]    tail_ptr [CHANNELS];
    logic [PTR_W-1:0]    head_ptr [CHANNELS];
    int unsigned         rr_channel;
    bit                  packet_dropping;
    logic [COUNT_W-1:0]  chan_count_reg;
    logic [THR_W-1:0]    thr_reg;
    logic                enable_reg;

    demux_result_t expected_results [$];

    function automatic logic [PTR_W-1:0] ring_advance(input logic [PTR_W-1:0] slot);
        return (int'(slot) == RING_DEPTH - 1) ? '0 : slot + 1'b1;
    endfunction

    // Apply one item to the mirrored state and return the result it should produce.
    function automatic demux_result_t demux_step(input logic act,
                                                 input logic [SAMPLE_W-1:0] smp,
                                                 input logic first,
                                                 input logic [POPCH_W-1:0] ch);
        demux_result_t r;
        int unsigned   active;
        int unsigned   target;
        logic [PTR_W-1:0] next_tail;
        int            fill;
        r = '{default: '0};
        if (act == ACT_PUSH) begin
            if (enable_reg) begin
                // A count of zero means one channel, anything past the rings means all of them.
                active = (chan_count_reg == 0) ? 1 :
                         (chan_count_reg > CHANNELS) ? CHANNELS : chan_count_reg;
                if (first) begin
                    rr_channel      = 0;
                    packet_dropping = 1'b0;
                end
                if (packet_dropping) begin
                    r.dropped = 1'b1;
                end
                else begin
                    target    = (rr_channel >= active) ? 0 : rr_channel;
                    next_tail = ring_advance(tail_ptr[target]);
                    if (next_tail == head_ptr[target]) begin
                        packet_dropping = 1'b1;
                        r.dropped       = 1'b1;
                    end
                    else begin
                        ring_mem[target][tail_ptr[target]] = smp;
                        tail_ptr[target] = next_tail;
                        rr_channel = (target + 1 >= active) ? 0 : target + 1;
                    end
                end
            end
        end
        else if (int'(ch) < CHANNELS && head_ptr[ch] != tail_ptr[ch]) begin
            r.read_value = VALUE_W'(ring_mem[ch][head_ptr[ch]]) - SAMPLE_OFFSET;
            r.read_valid = 1'b1;
            head_ptr[ch] = ring_advance(head_ptr[ch]);
        end
        // Block ready looks at channel 0 after this item has been applied.
        fill = (tail_ptr[0] >= head_ptr[0]) ? int'(tail_ptr[0]) - int'(head_ptr[0]) :
               RING_DEPTH - int'(head_ptr[0]) + int'(tail_ptr[0]);
        r.block_ready = (fill > int'(thr_reg));
        return r;
    endfunction

    // Track register writes and both streams at every rising edge.
    always @(posedge clk or negedge rst_n)
    begin : watch
        demux_result_t got;
        demux_result_t want;
        if (!rst_n) begin
            foreach (tail_ptr[i]) begin
                tail_ptr[i] = '0;
                head_ptr[i] = '0;
            end
            rr_channel      = 0;
            packet_dropping = 1'b0;
            chan_count_reg  = COUNT_W'(1);
            thr_reg         = THR_W'(1023);
            enable_reg      = 1'b0;
            expected_results.delete();
            mismatch_count  = 0;
        end
        else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_CHANNEL_COUNT:   chan_count_reg = cfg_data[COUNT_W-1:0];
                    CFG_BLOCK_THRESHOLD: thr_reg        = cfg_data[THR_W-1:0];
                    CFG_SAMPLING_ENABLE: enable_reg     = cfg_data[0];
                    default: ;
                endcase
            end

            // Result transfer: compare with the oldest prediction.
            if (m_tvalid && m_tready) begin
                got.block_ready = m_tdata[0];
                got.dropped     = m_tdata[1];
                got.read_value  = m_tdata[14:2];
                got.read_valid  = m_tdata[15];
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("%t unexpected result: ready=%0b drop=%0b value=%0d valid=%0b",
                                 $realtime, got.block_ready, got.dropped, got.read_value,
                                 got.read_valid);
                end
                else begin
                    want = expected_results.pop_front();
                    if (got.block_ready !== want.block_ready || got.dropped !== want.dropped ||
                        got.read_value !== want.read_value || got.read_valid !== want.read_valid)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_MAX)
                            $display({"%t result mismatch: expected ready=%0b drop=%0b value=%0d",
                                      " valid=%0b, got ready=%0b drop=%0b value=%0d valid=%0b"},
                                     $realtime, want.block_ready, want.dropped, want.read_value,
                                     want.read_valid, got.block_ready, got.dropped,
                                     got.read_value, got.read_valid);
                    end
                end
            end

            // Input transfer: predict its result.
            if (s_tvalid && s_tready)
                expected_results.push_back(demux_step(s_tuser[0], s_tdata[11:0], s_tuser[1],
                                                      s_tdata[14:12]));
        end
        pending = expected_results.size();
    end

endmodule

FILE: bench/tb_top.sv
// Testbench top: clock, reset, stimulus and the final verdict for the sample demultiplexer.
module tb_top;
    import msdf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_MAX  = 6;
    localparam int IDLE_LIMIT = 1000;
    localparam int PHASES     = 8;
    localparam int PHASE_LEN  = 12;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [15:0]          s_tdata   = '0;
    logic [1:0]           s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [15:0]          m_tdata;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;

    int mismatch_count;
    int pending;
    bit calm = 1'b0;   // both sides run without gaps while set

    // Register settings of the random phases.
    int phase_count [PHASES] = '{8, 3, 1, 0, 12, 2, 5, 15};
    int phase_thr   [PHASES] = '{0, 5, 1023, 2, 0, 700, 3, 1};
    bit phase_en    [PHASES] = '{1, 1, 1, 1, 1, 0, 1, 1};

    initial
    begin
        forever #4 clk = ~clk;
    end

    multichannel_sample_demux_fifo_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    demux_ring_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .pending        (pending)
    );

    // Offer one item after a random gap and hold it until the transfer; returns at a falling edge.
    task automatic send_item(input logic act, input logic [SAMPLE_W-1:0] smp,
                             input logic first, input logic [POPCH_W-1:0] ch);
        int gap;
        gap = calm ? 0 : $urandom_range(0, STALL_MAX);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, ch, smp};
        s_tuser  <= {first, act};
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
    endtask

    // Stop sending and wait until every predicted result has been taken.
    task automatic wait_drained;
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Write all three registers on consecutive cycles; unused upper bits carry noise.
    task automatic configure(input int count, input int thr, input bit en);
        logic [CFG_W-1:0] word;
        word = CFG_W'($urandom);
        word[COUNT_W-1:0] = COUNT_W'(count);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_CHANNEL_COUNT;
        cfg_data  <= word;
        @(negedge clk);
        cfg_index <= CFG_BLOCK_THRESHOLD;
        cfg_data  <= CFG_W'(thr);
        @(negedge clk);
        word = CFG_W'($urandom);
        word[0] = en;
        cfg_index <= CFG_SAMPLING_ENABLE;
        cfg_data  <= word;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Packet of pushes with random samples; the first one restarts the channel order.
    task automatic push_packet(input int len);
        for (int i = 0; i < len; i++)
            send_item(ACT_PUSH, SAMPLE_W'($urandom), i == 0, POPCH_W'($urandom));
    endtask

    // Receiver: a random stall before each result transfer.
    initial
    begin
        int gap;
        forever
        begin
            @(negedge clk);
            gap = calm ? 0 : $urandom_range(0, STALL_MAX);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!(m_tvalid && m_tready));
        end
    end

    // Watchdog: end the run when no transfer happens for too long.
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    // Main sequence.
    initial
    begin
        logic [SAMPLE_W-1:0] extremes [8];
        int sent;
        int kind;
        int len;
        extremes = '{12'h000, 12'hFFF, 12'h7FF, 12'h800, 12'h001, 12'hFFE, 12'hAAA, 12'h555};

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: sampling is off, so pushes vanish and pops find empty rings.
        send_item(ACT_POP, '0, 1'b0, POPCH_W'(0));
        send_item(ACT_POP, '0, 1'b0, POPCH_W'(7));
        send_item(ACT_PUSH, 12'hFFF, 1'b1, '0);
        wait_drained();

        // All eight channels, ready as soon as channel 0 holds anything.
        configure(8, 0, 1'b1);
        for (int i = 0; i < 8; i++)
            send_item(ACT_PUSH, extremes[i], i == 0, POPCH_W'(i));
        for (int i = 0; i < 8; i++)
            send_item(ACT_POP, '0, 1'b0, POPCH_W'(i));
        send_item(ACT_POP, '0, 1'b0, POPCH_W'(5));
        // A new packet in the middle of another goes back to channel 0.
        send_item(ACT_PUSH, 12'h123, 1'b1, '0);
        send_item(ACT_PUSH, 12'h456, 1'b0, '0);
        send_item(ACT_PUSH, 12'h789, 1'b0, '0);
        send_item(ACT_PUSH, 12'hABC, 1'b1, '0);
        send_item(ACT_POP, '0, 1'b0, POPCH_W'(0));
        wait_drained();

        // Random phases, each under its own register setting.
        for (int p = 0; p < PHASES; p++)
        begin
            configure(phase_count[p], phase_thr[p], phase_en[p]);
            // Continue the old channel order, which may now lie beyond the count.
            send_item(ACT_PUSH, SAMPLE_W'($urandom), 1'b0, POPCH_W'($urandom));
            sent = 0;
            while (sent < PHASE_LEN)
            begin
                calm = (p == 2) || ($urandom_range(0, 7) == 0);
                kind = $urandom_range(0, 99);
                if (kind < 55)
                begin
                    len = $urandom_range(1, 18);
                    push_packet(len);
                    sent += len;
                end
                else if (kind < 85)
                begin
                    len = $urandom_range(1, 4);
                    repeat (len) send_item(ACT_POP, SAMPLE_W'($urandom),
                                           1'($urandom_range(0, 1)), POPCH_W'($urandom));
                    sent += len;
                end
                else if (kind < 97)
                begin
                    send_item(ACT_PUSH, SAMPLE_W'($urandom), 1'($urandom_range(0, 1)),
                              POPCH_W'($urandom));
                    sent++;
                end
                else
                begin
                    wait_drained();
                end
            end
            calm = 1'b0;
            wait_drained();
        end

        // Fill channel 0 until packets start to drop, with the threshold just below full.
        configure(1, 1022, 1'b1);
        repeat (19) push_packet(55);
        push_packet(3);
        send_item(ACT_POP, '0, 1'b0, POPCH_W'(0));
        send_item(ACT_POP, '0, 1'b0, POPCH_W'(0));
        push_packet(3);
        wait_drained();

        // Highest threshold: a full channel 0 never counts as ready.
        configure(1, 1023, 1'b1);
        send_item(ACT_PUSH, SAMPLE_W'($urandom), 1'b1, '0);
        send_item(ACT_POP, '0, 1'b0, POPCH_W'(0));
        send_item(ACT_PUSH, SAMPLE_W'($urandom), 1'b1, '0);
        wait_drained();
        repeat (10) @(negedge clk);

        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/msdf_pkg.sv
rtl/core/msdf_sample_ram.sv
rtl/core/msdf_ring_ctrl.sv
rtl/core/multichannel_sample_demux_fifo_core.sv
bench/msdf_checker.sv
bench/tb_top.sv
